>>> hdl/pss_pkg.sv
`timescale 1ns / 1ps
package pss_pkg;

  // Table size and derived widths
  localparam int MAX_USERS = 64;
  localparam int IDX_W     = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int CNT_W     = $clog2(MAX_USERS + 1);

  // Item codes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_REG   = 2'd1;
  localparam logic [1:0] MODE_EMIT  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] user_id;
    logic [15:0] period;
  } pss_req_t;

  typedef struct packed {
    logic [15:0] sender_id;
    logic [1:0]  status;
  } pss_rsp_t;

  // One table entry as held in the store
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] period;
    logic [31:0] next_time;
  } pss_entry_t;

  // Write request into the entry store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    pss_entry_t       data;
  } pss_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } pss_state_e;

endpackage

>>> hdl/periodic_sender_scheduler.sv
`timescale 1ns / 1ps
// Periodic sender scheduler. Items are taken with start while busy is low;
// each item gives exactly one result, shown on rsp_o for a single cycle with
// valid_o high, and the receiver must take it then (no back-pressure).
// Clear, register and any item on an empty table are answered in the next
// cycle, and a new item may follow right away. An emit on a table of N
// entries scans them one per cycle through the registered read port of the
// entry store, then writes back the winner's advanced send time: busy stays
// high through the scan and the write-back, and the result is registered with the write-back.
// The entry store is not cleared at reset; fill count, state and valid_o are.
module periodic_sender_scheduler (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pss_pkg::pss_req_t req_i,
  output logic              valid_o,
  output pss_pkg::pss_rsp_t rsp_o
);
  import pss_pkg::*;

  pss_state_e       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  pss_entry_t       best_q, best_d;
  logic             valid_q, valid_d;
  pss_rsp_t         rsp_q, rsp_d;

  logic             accept;
  logic             full;
  logic             last;
  logic             take;
  logic [IDX_W-1:0] rd_addr;
  pss_entry_t       rd_data;
  pss_wr_t          wr;
  logic [32:0]      sum;

  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(MAX_USERS));
  assign last   = ((CNT_W'(cmp_idx_q) + CNT_W'(1)) == count_q);

  // The first entry is always taken; later ones win on strictly earlier time, then lower id
  assign take = (cmp_idx_q == '0) ||
                (rd_data.next_time < best_q.next_time) ||
                ((rd_data.next_time == best_q.next_time) && (rd_data.id < best_q.id));

  // Saturating advance of the winner's send time
  assign sum = {1'b0, best_q.next_time} + {17'b0, best_q.period};

  pss_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.mode == MODE_EMIT) && (count_q != '0)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath control and results
  always_comb begin
    count_d    = count_q;
    cmp_idx_d  = cmp_idx_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    valid_d    = 1'b0;
    rsp_d      = '{sender_id: 16'd0, status: ST_OK};
    rd_addr    = '0;
    wr         = '{en: 1'b0, addr: count_q[IDX_W-1:0],
                   data: '{id: req_i.user_id, period: req_i.period,
                           next_time: {16'd0, req_i.period}}};
    case (state_q)
      ST_IDLE: begin
        cmp_idx_d = '0;
        if (accept) begin
          case (req_i.mode)
            MODE_CLEAR: begin
              count_d = '0;
              valid_d = 1'b1;
            end
            MODE_REG: begin
              valid_d = 1'b1;
              if (full) begin
                rsp_d.status = ST_FULL;
              end else begin
                wr.en   = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            MODE_EMIT: begin
              if (count_q == '0) begin
                valid_d      = 1'b1;
                rsp_d.status = ST_EMPTY;
              end
            end
            default: valid_d = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        rd_addr   = cmp_idx_q + IDX_W'(1);
        cmp_idx_d = cmp_idx_q + IDX_W'(1);
        if (take) begin
          best_d     = rd_data;
          best_idx_d = cmp_idx_q;
        end
      end
      ST_UPDATE: begin
        wr.en             = 1'b1;
        wr.addr           = best_idx_q;
        wr.data           = best_q;
        wr.data.next_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        valid_d           = 1'b1;
        rsp_d.sender_id   = best_q.id;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    rsp_q      <= rsp_d;
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_USERS))
    else $error("entry count beyond table size");

  a_update_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |=> (valid_o && (rsp_o.status == ST_OK)))
    else $error("emit write-back without result");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result while scan in progress");

  a_empty_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.mode == MODE_EMIT) && (count_q == '0)) |=>
      (valid_o && (rsp_o.status == ST_EMPTY) && (rsp_o.sender_id == 16'd0)))
    else $error("empty emit not reported");

endmodule

>>> hdl/pss_store.sv
`timescale 1ns / 1ps
module pss_store (
  input  logic                      clk_i,
  input  pss_pkg::pss_wr_t          wr_i,
  input  logic [pss_pkg::IDX_W-1:0] rd_addr_i,
  output pss_pkg::pss_entry_t       rd_data_o
);
  import pss_pkg::*;

  pss_entry_t mem_q [MAX_USERS];
  pss_entry_t rd_data_q;

  // Single write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
